// ===== src/sbgc_pkg.sv =====
package sbgc_pkg;

    localparam int CFG_WIDTH = 24;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CODE_WIDTH = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int OUT_COUNT_WIDTH = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CYCLE_TIME = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SEGMENT_GAP = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LIFT_CONFIRM = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CLICK_TIME = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DOUBLE_CLICK_TIME = 3'd4;

    // Reset values of the configuration registers, microseconds
    localparam logic [CFG_WIDTH-1:0] CYCLE_TIME_RESET = 24'd10000;
    localparam logic [CFG_WIDTH-1:0] SEGMENT_GAP_RESET = 24'd400000;
    localparam logic [CFG_WIDTH-1:0] LIFT_CONFIRM_RESET = 24'd10000;
    localparam logic [CFG_WIDTH-1:0] CLICK_TIME_RESET = 24'd200000;
    localparam logic [CFG_WIDTH-1:0] DOUBLE_CLICK_TIME_RESET = 24'd400000;

    // Input event codes
    localparam logic [CODE_WIDTH-1:0] CODE_SYN = 16'h0000;
    localparam logic [CODE_WIDTH-1:0] CODE_PRESSURE = 16'h0018;
    localparam logic [CODE_WIDTH-1:0] CODE_DISTANCE = 16'h0019;
    localparam logic [CODE_WIDTH-1:0] CODE_TOOL_PEN = 16'h0140;
    localparam logic [CODE_WIDTH-1:0] CODE_STYLUS = 16'h014B;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_CLICK    = 3'd1,
        KIND_LONG     = 3'd2,
        KIND_HOLD_ON  = 3'd3,
        KIND_HOLD_OFF = 3'd4,
        KIND_PEN_UP   = 3'd5
    } gesture_kind_t;

endpackage

// ===== src/stylus_button_gesture_classifier.sv =====
// Stylus button and pen contact gesture classifier.
//
// Input channel: one pen event per item (event_code, event_value,
// timestamp_us) under in_valid / in_stall. Output channel: exactly one
// result per event (gesture_kind, gesture_count) under out_valid / out_stall.
// Configuration: five 24-bit time windows in microseconds, written through
// cfg_we / cfg_index / cfg_data while no item is in flight.
//
// The event is held in an input register, then one pass of subtract-and-compare
// logic updates the gesture state and loads the result register, which drives
// out_valid. Throughput is one item per cycle while the receiver does not
// stall; the result register frees as soon as the receiver takes its item,
// so the input register drains then.
//
// Reset clears all gesture state, empties both registers and restores the
// default windows. When the receiver stalls, the result holds; one more item
// is taken into the input register, after which in_stall rises until the
// result is taken. Counts saturate at all ones; gesture_count carries the low
// 16 bits of the count and is zero when gesture_kind is none.
module stylus_button_gesture_classifier #(
    parameter int COUNT_BITS = 16,
    parameter int TIME_BITS = 48
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [sbgc_pkg::CODE_WIDTH-1:0]        event_code,
    input  logic signed [sbgc_pkg::VALUE_WIDTH-1:0] event_value,
    input  logic [TIME_BITS-1:0]                   timestamp_us,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [2:0]                             gesture_kind,
    output logic [sbgc_pkg::OUT_COUNT_WIDTH-1:0]   gesture_count,
    input  logic                                   cfg_we,
    input  logic [sbgc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [sbgc_pkg::CFG_WIDTH-1:0]         cfg_data
);

    localparam int CW = (COUNT_BITS > sbgc_pkg::OUT_COUNT_WIDTH) ? COUNT_BITS
                                                               : sbgc_pkg::OUT_COUNT_WIDTH;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    // elapsed (now - then) strictly greater than win; a negative elapsed never is
    function automatic logic elapsed_gt(time_t now, time_t then,
                                        logic [sbgc_pkg::CFG_WIDTH-1:0] win);
        logic [TIME_BITS:0] d;
        d = {1'b0, now} - {1'b0, then};
        return !d[TIME_BITS] && (d[TIME_BITS-1:0] > TIME_BITS'(win));
    endfunction

    // elapsed (now - then) strictly less than win; a negative elapsed always is
    function automatic logic elapsed_lt(time_t now, time_t then,
                                        logic [sbgc_pkg::CFG_WIDTH-1:0] win);
        logic [TIME_BITS:0] d;
        d = {1'b0, now} - {1'b0, then};
        return d[TIME_BITS] || (d[TIME_BITS-1:0] < TIME_BITS'(win));
    endfunction

    function automatic count_t sat_inc(count_t c);
        return (c == COUNT_MAX) ? c : c + count_t'(1);
    endfunction

    // ---------------------------------------------------------------- config
    logic [sbgc_pkg::CFG_WIDTH-1:0] cycle_time_reg, segment_gap_reg, lift_confirm_reg;
    logic [sbgc_pkg::CFG_WIDTH-1:0] click_time_reg, double_click_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_time_reg        <= sbgc_pkg::CYCLE_TIME_RESET;
            segment_gap_reg       <= sbgc_pkg::SEGMENT_GAP_RESET;
            lift_confirm_reg      <= sbgc_pkg::LIFT_CONFIRM_RESET;
            click_time_reg        <= sbgc_pkg::CLICK_TIME_RESET;
            double_click_time_reg <= sbgc_pkg::DOUBLE_CLICK_TIME_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sbgc_pkg::CFG_CYCLE_TIME:        cycle_time_reg <= cfg_data;
                sbgc_pkg::CFG_SEGMENT_GAP:       segment_gap_reg <= cfg_data;
                sbgc_pkg::CFG_LIFT_CONFIRM:      lift_confirm_reg <= cfg_data;
                sbgc_pkg::CFG_CLICK_TIME:        click_time_reg <= cfg_data;
                sbgc_pkg::CFG_DOUBLE_CLICK_TIME: double_click_time_reg <= cfg_data;
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // ------------------------------------------------------- pipeline control
    logic s1_valid_reg, s1_valid_next;
    logic [sbgc_pkg::CODE_WIDTH-1:0] s1_code_reg;
    logic [sbgc_pkg::VALUE_WIDTH-1:0] s1_value_reg;
    time_t s1_time_reg;

    logic res_valid_reg, res_valid_next;
    sbgc_pkg::gesture_kind_t res_kind_reg;
    logic [sbgc_pkg::OUT_COUNT_WIDTH-1:0] res_count_reg;

    logic advance;
    logic accept;

    // The event in the input register moves on when the result slot is free
    // or is being emptied in this cycle.
    assign advance  = s1_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (advance)
            res_valid_next = 1'b1;
        else if (!out_stall)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_code_reg  <= event_code;
            s1_value_reg <= event_value;
            s1_time_reg  <= timestamp_us;
        end
    end

    // --------------------------------------------------------- gesture state
    count_t click_count_reg, click_count_next;
    count_t segment_count_reg, segment_count_next;
    logic click_registered_reg, click_registered_next;
    logic hold_sent_reg, hold_sent_next;
    logic abort_pending_reg, abort_pending_next;
    logic in_contact_reg, in_contact_next;
    logic release_pending_reg, release_pending_next;
    logic long_click_possible_reg, long_click_possible_next;
    logic long_click_due_reg, long_click_due_next;
    logic lift_pending_reg, lift_pending_next;
    logic lift_saw_click_reg, lift_saw_click_next;
    logic lift_saw_contact_reg, lift_saw_contact_next;
    time_t press_time_reg, press_time_next;
    time_t abort_time_reg, abort_time_next;
    time_t last_segment_time_reg, last_segment_time_next;
    time_t release_time_reg, release_time_next;
    time_t lift_time_reg, lift_time_next;

    sbgc_pkg::gesture_kind_t kind;
    count_t cnt;
    logic [CW-1:0] cnt_wide;
    logic released;
    logic v0, v1;
    logic is_syn, is_stylus, is_distance, is_pressure, is_tool_pen;

    assign v0          = (s1_value_reg == '0);
    assign v1          = (s1_value_reg == sbgc_pkg::VALUE_WIDTH'(1));
    assign is_syn      = (s1_code_reg == sbgc_pkg::CODE_SYN);
    assign is_stylus   = (s1_code_reg == sbgc_pkg::CODE_STYLUS);
    assign is_distance = (s1_code_reg == sbgc_pkg::CODE_DISTANCE);
    assign is_pressure = (s1_code_reg == sbgc_pkg::CODE_PRESSURE);
    assign is_tool_pen = (s1_code_reg == sbgc_pkg::CODE_TOOL_PEN);

    // One pass over the rules in order; a later rule overrides the result.
    always_comb
    begin
        click_count_next         = click_count_reg;
        segment_count_next       = segment_count_reg;
        click_registered_next    = click_registered_reg;
        hold_sent_next           = hold_sent_reg;
        abort_pending_next       = abort_pending_reg;
        in_contact_next          = in_contact_reg;
        release_pending_next     = release_pending_reg;
        long_click_possible_next = long_click_possible_reg;
        long_click_due_next      = long_click_due_reg;
        lift_pending_next        = lift_pending_reg;
        lift_saw_click_next      = lift_saw_click_reg;
        lift_saw_contact_next    = lift_saw_contact_reg;
        press_time_next          = press_time_reg;
        abort_time_next          = abort_time_reg;
        last_segment_time_next   = last_segment_time_reg;
        release_time_next        = release_time_reg;
        lift_time_next           = lift_time_reg;
        kind     = sbgc_pkg::KIND_NONE;
        cnt      = '0;
        released = 1'b0;

        // Abort once the pen was withdrawn and came back after the window
        if (abort_pending_next && !is_syn && !is_stylus)
        begin
            abort_pending_next = 1'b0;
            if (elapsed_gt(s1_time_reg, abort_time_next, cycle_time_reg))
            begin
                click_registered_next    = 1'b0;
                long_click_possible_next = 1'b0;
                long_click_due_next      = 1'b0;
                in_contact_next          = 1'b0;
                lift_pending_next        = 1'b0;
                lift_saw_contact_next    = 1'b0;
                lift_saw_click_next      = 1'b0;
                if (hold_sent_next)
                begin
                    kind = sbgc_pkg::KIND_HOLD_OFF;
                    cnt  = click_count_next;
                    hold_sent_next = 1'b0;
                end
                click_count_next   = '0;
                segment_count_next = '0;
            end
        end
        if (is_tool_pen && v0)
        begin
            abort_time_next    = s1_time_reg;
            abort_pending_next = 1'b1;
        end

        // Contact and lift tracking; a click plus contact during a possible
        // lift marks it as fake.
        if (lift_pending_next)
        begin
            if (elapsed_gt(s1_time_reg, lift_time_next, lift_confirm_reg))
            begin
                lift_saw_contact_next = 1'b0;
                lift_saw_click_next   = 1'b0;
                lift_pending_next     = 1'b0;
                in_contact_next       = 1'b0;
                kind = sbgc_pkg::KIND_PEN_UP;
                cnt  = segment_count_next;
            end
            else
            begin
                if (is_stylus && v1)
                    lift_saw_click_next = 1'b1;
                if (is_distance && v0)
                    lift_saw_contact_next = 1'b1;
                if (lift_saw_click_next && lift_saw_contact_next)
                begin
                    lift_saw_contact_next = 1'b0;
                    lift_saw_click_next   = 1'b0;
                    lift_pending_next     = 1'b0;
                end
            end
        end
        else if (in_contact_next)
        begin
            if (is_distance)
            begin
                lift_time_next    = s1_time_reg;
                lift_pending_next = 1'b1;
            end
        end
        else if (is_distance && v0)
        begin
            if (elapsed_gt(s1_time_reg, last_segment_time_next, segment_gap_reg))
                segment_count_next = '0;
            in_contact_next = 1'b1;
        end

        // Debounced button release
        if (!is_syn && release_pending_next)
        begin
            release_pending_next = 1'b0;
            released = elapsed_lt(s1_time_reg, release_time_next, cycle_time_reg);
        end
        if (is_stylus && v0)
        begin
            release_time_next    = s1_time_reg;
            release_pending_next = 1'b1;
        end

        if (hold_sent_next && is_pressure)
            long_click_possible_next = 1'b0;
        if (is_pressure && v0)
        begin
            segment_count_next     = sat_inc(segment_count_next);
            last_segment_time_next = s1_time_reg;
        end

        // Button press while hovering
        if (is_stylus && v1 && !in_contact_next)
        begin
            press_time_next       = s1_time_reg;
            click_count_next      = sat_inc(click_count_next);
            click_registered_next = 1'b0;
        end

        if (long_click_due_next)
        begin
            kind = sbgc_pkg::KIND_LONG;
            cnt  = click_count_next;
            click_count_next         = '0;
            long_click_due_next      = 1'b0;
            long_click_possible_next = 1'b0;
        end

        // Click or hold classification by time since the press
        if (click_count_next != '0)
        begin
            if (elapsed_lt(s1_time_reg, press_time_next, click_time_reg))
            begin
                if (released)
                    click_registered_next = 1'b1;
            end
            else if (elapsed_lt(s1_time_reg, press_time_next, double_click_time_reg))
            begin
                if (!click_registered_next)
                begin
                    if (!hold_sent_next)
                    begin
                        kind = sbgc_pkg::KIND_HOLD_ON;
                        cnt  = click_count_next;
                        hold_sent_next           = 1'b1;
                        long_click_possible_next = 1'b1;
                    end
                    if (hold_sent_next && released)
                    begin
                        kind = sbgc_pkg::KIND_HOLD_OFF;
                        cnt  = click_count_next;
                        hold_sent_next = 1'b0;
                        if (long_click_possible_next)
                            long_click_due_next = 1'b1;
                        else
                            click_count_next = '0;
                    end
                end
            end
            else
            begin
                if (click_registered_next)
                begin
                    kind = sbgc_pkg::KIND_CLICK;
                    cnt  = click_count_next;
                    click_registered_next = 1'b0;
                    click_count_next      = '0;
                end
                if (released)
                begin
                    kind = sbgc_pkg::KIND_HOLD_OFF;
                    cnt  = click_count_next;
                    hold_sent_next = 1'b0;
                    if (long_click_possible_next)
                        long_click_due_next = 1'b1;
                    else
                        click_count_next = '0;
                end
            end
        end

        if (kind == sbgc_pkg::KIND_NONE)
            cnt = '0;
        cnt_wide = CW'(cnt);
    end

    // Advance the state only as the event leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            click_count_reg         <= '0;
            segment_count_reg       <= '0;
            click_registered_reg    <= 1'b0;
            hold_sent_reg           <= 1'b0;
            abort_pending_reg       <= 1'b0;
            in_contact_reg          <= 1'b0;
            release_pending_reg     <= 1'b0;
            long_click_possible_reg <= 1'b0;
            long_click_due_reg      <= 1'b0;
            lift_pending_reg        <= 1'b0;
            lift_saw_click_reg      <= 1'b0;
            lift_saw_contact_reg    <= 1'b0;
            press_time_reg          <= '0;
            abort_time_reg          <= '0;
            last_segment_time_reg   <= '0;
            release_time_reg        <= '0;
            lift_time_reg           <= '0;
        end
        else if (advance)
        begin
            click_count_reg         <= click_count_next;
            segment_count_reg       <= segment_count_next;
            click_registered_reg    <= click_registered_next;
            hold_sent_reg           <= hold_sent_next;
            abort_pending_reg       <= abort_pending_next;
            in_contact_reg          <= in_contact_next;
            release_pending_reg     <= release_pending_next;
            long_click_possible_reg <= long_click_possible_next;
            long_click_due_reg      <= long_click_due_next;
            lift_pending_reg        <= lift_pending_next;
            lift_saw_click_reg      <= lift_saw_click_next;
            lift_saw_contact_reg    <= lift_saw_contact_next;
            press_time_reg          <= press_time_next;
            abort_time_reg          <= abort_time_next;
            last_segment_time_reg   <= last_segment_time_next;
            release_time_reg        <= release_time_next;
            lift_time_reg           <= lift_time_next;
        end
    end

    // Result register: load on advance, hold while stalled
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_kind_reg  <= kind;
            res_count_reg <= cnt_wide[sbgc_pkg::OUT_COUNT_WIDTH-1:0];
        end
    end

    assign out_valid     = res_valid_reg;
    assign gesture_kind  = res_kind_reg;
    assign gesture_count = res_count_reg;

    // ------------------------------------------------------------ assertions
    a_state_holds_without_advance: assert property (
        @(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(click_count_reg) && $stable(segment_count_reg)
                      && $stable(hold_sent_reg) && $stable(in_contact_reg))
    ) else $error("gesture state changed with no item advancing");

    a_none_has_zero_count: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_kind_reg == sbgc_pkg::KIND_NONE) |-> (res_count_reg == '0)
    ) else $error("empty result carries a nonzero count");

    a_lift_needs_contact: assert property (
        @(posedge clk) disable iff (!rst_n)
        lift_pending_reg |-> in_contact_reg
    ) else $error("lift pending while not in contact");

    a_lift_marks_need_pending: assert property (
        @(posedge clk) disable iff (!rst_n)
        (lift_saw_click_reg || lift_saw_contact_reg) |-> lift_pending_reg
    ) else $error("lift marks set with no lift pending");

    a_advance_loads_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg
    ) else $error("advanced item did not reach the result register");

endmodule

// ===== verif/stylus_button_gesture_classifier_checker.sv =====
`timescale 1ns / 100ps

module stylus_button_gesture_classifier_checker #(
    parameter int COUNT_BITS = 16,
    parameter int TIME_BITS = 48
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic                                    in_stall,
    input  logic [sbgc_pkg::CODE_WIDTH-1:0]         event_code,
    input  logic signed [sbgc_pkg::VALUE_WIDTH-1:0] event_value,
    input  logic [TIME_BITS-1:0]                    timestamp_us,
    input  logic                                    out_valid,
    input  logic                                    out_stall,
    input  logic [2:0]                              gesture_kind,
    input  logic [sbgc_pkg::OUT_COUNT_WIDTH-1:0]    gesture_count,
    input  logic                                    cfg_we,
    input  logic [sbgc_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [sbgc_pkg::CFG_WIDTH-1:0]          cfg_data,
    output int                                      mismatches,
    output int                                      results_owed
);

    typedef struct packed {
        sbgc_pkg::gesture_kind_t              kind;
        logic [sbgc_pkg::OUT_COUNT_WIDTH-1:0] count;
    } gesture_t;

    gesture_t pending_gestures [$];

    logic [sbgc_pkg::CFG_WIDTH-1:0] win_cycle, win_gap, win_lift, win_click, win_double;

    logic [COUNT_BITS-1:0] clicks, segments;
    logic click_reg, hold_active, abort_armed, in_contact, release_armed;
    logic long_possible, long_due, lift_armed, lift_click, lift_contact;
    logic [TIME_BITS-1:0] press_at, abort_at, last_segment_at, release_at, lift_at;

    // backward time never exceeds a window and is always inside one
    function automatic logic past_window(input logic [TIME_BITS-1:0] now,
                                         input logic [TIME_BITS-1:0] then,
                                         input logic [sbgc_pkg::CFG_WIDTH-1:0] w);
        return (now > then) && ((now - then) > TIME_BITS'(w));
    endfunction

    function automatic logic within_window(input logic [TIME_BITS-1:0] now,
                                           input logic [TIME_BITS-1:0] then,
                                           input logic [sbgc_pkg::CFG_WIDTH-1:0] w);
        return (now < then) || ((now - then) < TIME_BITS'(w));
    endfunction

    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
        return (c == {COUNT_BITS{1'b1}}) ? c : c + COUNT_BITS'(1);
    endfunction

    // Advance the gesture state by one event; later rules override the result.
    task automatic classify_event(input logic [sbgc_pkg::CODE_WIDTH-1:0] code,
                                  input logic signed [sbgc_pkg::VALUE_WIDTH-1:0] value,
                                  input logic [TIME_BITS-1:0] t,
                                  output gesture_t res);
        logic is0, is1, released;
        sbgc_pkg::gesture_kind_t kind;
        logic [COUNT_BITS-1:0] cnt;
        is0 = (value == 0);
        is1 = (value == 1);
        released = 1'b0;
        kind = sbgc_pkg::KIND_NONE;
        cnt = '0;

        if (abort_armed && code != sbgc_pkg::CODE_SYN && code != sbgc_pkg::CODE_STYLUS) begin
            abort_armed = 1'b0;
            if (past_window(t, abort_at, win_cycle)) begin
                click_reg = 1'b0;
                long_possible = 1'b0;
                long_due = 1'b0;
                in_contact = 1'b0;
                lift_armed = 1'b0;
                lift_contact = 1'b0;
                lift_click = 1'b0;
                if (hold_active) begin
                    kind = sbgc_pkg::KIND_HOLD_OFF;
                    cnt = clicks;
                    hold_active = 1'b0;
                end
                clicks = '0;
                segments = '0;
            end
        end
        if (code == sbgc_pkg::CODE_TOOL_PEN && is0) begin
            abort_at = t;
            abort_armed = 1'b1;
        end

        if (lift_armed) begin
            if (past_window(t, lift_at, win_lift)) begin
                lift_contact = 1'b0;
                lift_click = 1'b0;
                lift_armed = 1'b0;
                in_contact = 1'b0;
                kind = sbgc_pkg::KIND_PEN_UP;
                cnt = segments;
            end
            else begin
                if (code == sbgc_pkg::CODE_STYLUS && is1) lift_click = 1'b1;
                if (code == sbgc_pkg::CODE_DISTANCE && is0) lift_contact = 1'b1;
                if (lift_click && lift_contact) begin
                    lift_contact = 1'b0;
                    lift_click = 1'b0;
                    lift_armed = 1'b0;
                end
            end
        end
        else if (in_contact) begin
            if (code == sbgc_pkg::CODE_DISTANCE) begin
                lift_at = t;
                lift_armed = 1'b1;
            end
        end
        else if (code == sbgc_pkg::CODE_DISTANCE && is0) begin
            if (past_window(t, last_segment_at, win_gap)) segments = '0;
            in_contact = 1'b1;
        end

        if (code != sbgc_pkg::CODE_SYN && release_armed) begin
            release_armed = 1'b0;
            released = within_window(t, release_at, win_cycle);
        end
        if (code == sbgc_pkg::CODE_STYLUS && is0) begin
            release_at = t;
            release_armed = 1'b1;
        end

        if (hold_active && code == sbgc_pkg::CODE_PRESSURE) long_possible = 1'b0;
        if (code == sbgc_pkg::CODE_PRESSURE && is0) begin
            segments = bump(segments);
            last_segment_at = t;
        end

        if (code == sbgc_pkg::CODE_STYLUS && is1 && !in_contact) begin
            press_at = t;
            clicks = bump(clicks);
            click_reg = 1'b0;
        end

        if (long_due) begin
            kind = sbgc_pkg::KIND_LONG;
            cnt = clicks;
            clicks = '0;
            long_due = 1'b0;
            long_possible = 1'b0;
        end

        if (clicks != 0) begin
            if (within_window(t, press_at, win_click)) begin
                if (released) click_reg = 1'b1;
            end
            else if (within_window(t, press_at, win_double)) begin
                if (!click_reg) begin
                    if (!hold_active) begin
                        kind = sbgc_pkg::KIND_HOLD_ON;
                        cnt = clicks;
                        hold_active = 1'b1;
                        long_possible = 1'b1;
                    end
                    if (hold_active && released) begin
                        kind = sbgc_pkg::KIND_HOLD_OFF;
                        cnt = clicks;
                        hold_active = 1'b0;
                        if (long_possible) long_due = 1'b1;
                        else clicks = '0;
                    end
                end
            end
            else begin
                if (click_reg) begin
                    kind = sbgc_pkg::KIND_CLICK;
                    cnt = clicks;
                    click_reg = 1'b0;
                    clicks = '0;
                end
                if (released) begin
                    kind = sbgc_pkg::KIND_HOLD_OFF;
                    cnt = clicks;
                    hold_active = 1'b0;
                    if (long_possible) long_due = 1'b1;
                    else clicks = '0;
                end
            end
        end

        if (kind == sbgc_pkg::KIND_NONE) cnt = '0;
        res.kind = kind;
        res.count = sbgc_pkg::OUT_COUNT_WIDTH'(cnt);
    endtask

    task automatic flag_mismatch(input string why, input gesture_t want);
        mismatches = mismatches + 1;
        if (mismatches <= 10)
            $display("%0t mismatch (%s): expected kind %0d count %0d, got kind %0d count %0d",
                     $realtime, why, want.kind, want.count, gesture_kind, gesture_count);
    endtask

    always @(posedge clk or negedge rst_n) begin
        gesture_t want;
        gesture_t got_next;
        if (!rst_n) begin
            pending_gestures.delete();
            mismatches = 0;
            results_owed <= 0;
            win_cycle = sbgc_pkg::CYCLE_TIME_RESET;
            win_gap = sbgc_pkg::SEGMENT_GAP_RESET;
            win_lift = sbgc_pkg::LIFT_CONFIRM_RESET;
            win_click = sbgc_pkg::CLICK_TIME_RESET;
            win_double = sbgc_pkg::DOUBLE_CLICK_TIME_RESET;
            clicks = '0;
            segments = '0;
            click_reg = 1'b0;
            hold_active = 1'b0;
            abort_armed = 1'b0;
            in_contact = 1'b0;
            release_armed = 1'b0;
            long_possible = 1'b0;
            long_due = 1'b0;
            lift_armed = 1'b0;
            lift_click = 1'b0;
            lift_contact = 1'b0;
            press_at = '0;
            abort_at = '0;
            last_segment_at = '0;
            release_at = '0;
            lift_at = '0;
        end
        else begin
            // check the result leaving first: the item entering now cannot be it
            if (out_valid && !out_stall) begin
                if (pending_gestures.size() == 0) begin
                    want = '0;
                    flag_mismatch("no result expected", want);
                end
                else begin
                    want = pending_gestures.pop_front();
                    if (gesture_kind !== want.kind || gesture_count !== want.count)
                        flag_mismatch("wrong field", want);
                end
            end
            if (in_valid && !in_stall) begin
                classify_event(event_code, event_value, timestamp_us, got_next);
                pending_gestures.push_back(got_next);
            end
            if (cfg_we) begin
                case (cfg_index)
                    sbgc_pkg::CFG_CYCLE_TIME:        win_cycle = cfg_data;
                    sbgc_pkg::CFG_SEGMENT_GAP:       win_gap = cfg_data;
                    sbgc_pkg::CFG_LIFT_CONFIRM:      win_lift = cfg_data;
                    sbgc_pkg::CFG_CLICK_TIME:        win_click = cfg_data;
                    sbgc_pkg::CFG_DOUBLE_CLICK_TIME: win_double = cfg_data;
                    default: ;
                endcase
            end
            results_owed <= pending_gestures.size();
        end
    end

endmodule

// ===== verif/stylus_button_gesture_classifier_tb.sv =====
`timescale 1ns / 100ps

// Top of the gesture classifier bench: makes pen events, varies the time
// windows between phases, shapes both handshakes and gives the verdict. The
// checker beside the block watches both channels and counts mismatches.
module stylus_button_gesture_classifier_tb;

    localparam int COUNT_BITS = 16;
    localparam int TIME_BITS = 48;
    localparam int ITEMS_PER_PHASE = 330;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int BURST_PRESSES = 40;
    localparam longint RUN_LIMIT_NS = 64'd600_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [sbgc_pkg::CODE_WIDTH-1:0] event_code = '0;
    logic signed [sbgc_pkg::VALUE_WIDTH-1:0] event_value = '0;
    logic [TIME_BITS-1:0] timestamp_us = '0;
    logic out_stall = 1'b0;
    logic cfg_we = 1'b0;
    logic [sbgc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [sbgc_pkg::CFG_WIDTH-1:0] cfg_data = '0;

    logic in_stall;
    logic out_valid;
    logic [2:0] gesture_kind;
    logic [sbgc_pkg::OUT_COUNT_WIDTH-1:0] gesture_count;

    int mismatches;
    int results_owed;

    // knobs shared by the sender and the receiver process
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_requests = 0;
    int items_sent = 0;

    // time base of the pen stream and the windows now programmed; these only
    // steer the stimulus toward the window edges
    logic [TIME_BITS-1:0] now_us = '0;
    logic [sbgc_pkg::CFG_WIDTH-1:0] win_now [5];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    stylus_button_gesture_classifier #(
        .COUNT_BITS (COUNT_BITS),
        .TIME_BITS  (TIME_BITS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .event_code    (event_code),
        .event_value   (event_value),
        .timestamp_us  (timestamp_us),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .gesture_kind  (gesture_kind),
        .gesture_count (gesture_count),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    stylus_button_gesture_classifier_checker #(
        .COUNT_BITS (COUNT_BITS),
        .TIME_BITS  (TIME_BITS)
    ) chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .event_code    (event_code),
        .event_value   (event_value),
        .timestamp_us  (timestamp_us),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .gesture_kind  (gesture_kind),
        .gesture_count (gesture_count),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .results_owed  (results_owed)
    );

    // Receiver: random stalls, plus a long hold-off on request. The hold-off
    // is counted here so the sender keeps offering items meanwhile and the
    // block backs up into its input.
    initial
    begin
        int hold_left;
        int hold_offs_served;
        hold_left = 0;
        hold_offs_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_requests != hold_offs_served)
            begin
                hold_offs_served = hold_off_requests;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left = hold_left - 1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Offer one event and hold it until the block takes it. Called at a
    // rising edge; returns at the edge where the item was accepted, with
    // valid still high so back-to-back items need no second assignment.
    task automatic post_event(input logic [sbgc_pkg::CODE_WIDTH-1:0] code,
                              input logic signed [sbgc_pkg::VALUE_WIDTH-1:0] value,
                              input logic [TIME_BITS-1:0] stamp);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        event_code <= code;
        event_value <= value;
        timestamp_us <= stamp;
        now_us = stamp;
        do
            @(posedge clk);
        while (in_stall);
        items_sent = items_sent + 1;
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic drain;
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (results_owed != 0);
    endtask

    // Program all five windows back to back; only call with the block idle.
    task automatic program_windows(input logic [sbgc_pkg::CFG_WIDTH-1:0] cyc,
                                   input logic [sbgc_pkg::CFG_WIDTH-1:0] gap,
                                   input logic [sbgc_pkg::CFG_WIDTH-1:0] lift,
                                   input logic [sbgc_pkg::CFG_WIDTH-1:0] click,
                                   input logic [sbgc_pkg::CFG_WIDTH-1:0] dbl);
        logic [sbgc_pkg::CFG_WIDTH-1:0] vals [5];
        vals[sbgc_pkg::CFG_CYCLE_TIME] = cyc;
        vals[sbgc_pkg::CFG_SEGMENT_GAP] = gap;
        vals[sbgc_pkg::CFG_LIFT_CONFIRM] = lift;
        vals[sbgc_pkg::CFG_CLICK_TIME] = click;
        vals[sbgc_pkg::CFG_DOUBLE_CLICK_TIME] = dbl;
        for (int i = 0; i < 5; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= sbgc_pkg::CFG_INDEX_WIDTH'(i);
            cfg_data <= vals[sbgc_pkg::CFG_INDEX_WIDTH'(i)];
            win_now[sbgc_pkg::CFG_INDEX_WIDTH'(i)] = vals[sbgc_pkg::CFG_INDEX_WIDTH'(i)];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Random step of at most hi microseconds, sized for the time base.
    function automatic logic [TIME_BITS-1:0] rnd_step(input int unsigned hi);
        return TIME_BITS'($urandom_range(0, hi));
    endfunction

    // A step that lands on, just beside, below or above a window.
    function automatic logic [TIME_BITS-1:0] near(input logic [sbgc_pkg::CFG_WIDTH-1:0] w);
        logic [TIME_BITS-1:0] d;
        case ($urandom_range(0, 3))
            0, 1:
            begin
                d = TIME_BITS'(w) + rnd_step(4);
                d = (d >= 2) ? d - 2 : '0;
            end
            2: d = rnd_step(w);
            default: d = TIME_BITS'(w) + rnd_step(w + 2);
        endcase
        return d;
    endfunction

    // Free-running step: mostly small or window-sized, now and then a huge
    // jump forward or a step back in time.
    function automatic logic [TIME_BITS-1:0] wander();
        int r;
        logic [sbgc_pkg::CFG_WIDTH-1:0] w;
        logic [TIME_BITS-1:0] d;
        r = $urandom_range(0, 99);
        w = win_now[sbgc_pkg::CFG_INDEX_WIDTH'($urandom_range(0, 4))];
        if (r < 10) d = '0;
        else if (r < 45) d = rnd_step(w / 8 + 2);
        else if (r < 75) d = near(w);
        else if (r < 95) d = rnd_step(2 * w + 2);
        else if (r < 98) d = TIME_BITS'({$urandom, $urandom});
        else d = '0 - TIME_BITS'($urandom_range(1, w + 2));
        return d;
    endfunction

    function automatic logic signed [sbgc_pkg::VALUE_WIDTH-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        else if (r < 90) return 1;
        else return $urandom;
    endfunction

    function automatic logic [sbgc_pkg::CODE_WIDTH-1:0] pick_code();
        case ($urandom_range(0, 11))
            0, 1:    return sbgc_pkg::CODE_SYN;
            2, 3:    return sbgc_pkg::CODE_PRESSURE;
            4, 5:    return sbgc_pkg::CODE_DISTANCE;
            6, 7:    return sbgc_pkg::CODE_TOOL_PEN;
            8, 9:    return sbgc_pkg::CODE_STYLUS;
            default: return sbgc_pkg::CODE_WIDTH'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // One gesture with random content and timing around the current windows.
    task automatic play_gesture;
        logic [sbgc_pkg::CODE_WIDTH-1:0] consume_code;
        case ($urandom_range(0, 5))
            0:
            begin
                // single or multiple click
                repeat ($urandom_range(1, 3))
                begin
                    post_event(sbgc_pkg::CODE_STYLUS, 1, now_us + wander());
                    post_event(sbgc_pkg::CODE_STYLUS, 0,
                               now_us + rnd_step(win_now[sbgc_pkg::CFG_CLICK_TIME]));
                end
                if ($urandom_range(0, 1))
                    post_event(sbgc_pkg::CODE_SYN, pick_value(), now_us + rnd_step(50));
                consume_code = $urandom_range(0, 1) ? sbgc_pkg::CODE_PRESSURE : pick_code();
                post_event(consume_code, pick_value(),
                           now_us + near(win_now[sbgc_pkg::CFG_CYCLE_TIME]));
                post_event(sbgc_pkg::CODE_SYN, 0,
                           now_us + near(win_now[sbgc_pkg::CFG_DOUBLE_CLICK_TIME]));
            end
            1:
            begin
                // press and hold, release, maybe a long click
                post_event(sbgc_pkg::CODE_STYLUS, 1, now_us + wander());
                post_event(sbgc_pkg::CODE_SYN, 0,
                           now_us + near(win_now[sbgc_pkg::CFG_CLICK_TIME]));
                if ($urandom_range(0, 2) == 0)
                    post_event(sbgc_pkg::CODE_PRESSURE, pick_value(), now_us + rnd_step(50));
                post_event(sbgc_pkg::CODE_STYLUS, 0,
                           now_us + rnd_step(win_now[sbgc_pkg::CFG_DOUBLE_CLICK_TIME]));
                post_event(pick_code(), pick_value(),
                           now_us + near(win_now[sbgc_pkg::CFG_CYCLE_TIME]));
                post_event(sbgc_pkg::CODE_SYN, 0, now_us + rnd_step(3));
                post_event(sbgc_pkg::CODE_SYN, 0,
                           now_us + near(win_now[sbgc_pkg::CFG_DOUBLE_CLICK_TIME]));
            end
            2:
            begin
                // pen stroke: contact, pressure segments, lift, maybe fake lift
                post_event(sbgc_pkg::CODE_DISTANCE, 0,
                           now_us + near(win_now[sbgc_pkg::CFG_SEGMENT_GAP]));
                repeat ($urandom_range(1, 4))
                    post_event(sbgc_pkg::CODE_PRESSURE, $urandom_range(0, 1),
                               now_us + rnd_step(win_now[sbgc_pkg::CFG_LIFT_CONFIRM] + 1));
                post_event(sbgc_pkg::CODE_DISTANCE, pick_value(), now_us + rnd_step(20));
                if ($urandom_range(0, 1))
                begin
                    if ($urandom_range(0, 1))
                    begin
                        post_event(sbgc_pkg::CODE_STYLUS, 1,
                                   now_us + rnd_step(win_now[sbgc_pkg::CFG_LIFT_CONFIRM]));
                        post_event(sbgc_pkg::CODE_DISTANCE, 0,
                                   now_us + rnd_step(win_now[sbgc_pkg::CFG_LIFT_CONFIRM]));
                    end
                    else
                    begin
                        post_event(sbgc_pkg::CODE_DISTANCE, 0,
                                   now_us + rnd_step(win_now[sbgc_pkg::CFG_LIFT_CONFIRM]));
                        post_event(sbgc_pkg::CODE_STYLUS, 1,
                                   now_us + rnd_step(win_now[sbgc_pkg::CFG_LIFT_CONFIRM]));
                    end
                end
                post_event(sbgc_pkg::CODE_SYN, 0,
                           now_us + near(win_now[sbgc_pkg::CFG_LIFT_CONFIRM]));
            end
            3:
            begin
                // withdrawal and return of the pen
                post_event(sbgc_pkg::CODE_TOOL_PEN, 0, now_us + wander());
                if ($urandom_range(0, 1))
                    post_event(pick_code(), pick_value(),
                               now_us + rnd_step(win_now[sbgc_pkg::CFG_CYCLE_TIME]));
                post_event(sbgc_pkg::CODE_TOOL_PEN, 1,
                           now_us + near(win_now[sbgc_pkg::CFG_CYCLE_TIME]));
            end
            default:
            begin
                repeat ($urandom_range(1, 3))
                    post_event(pick_code(), pick_value(), now_us + wander());
            end
        endcase
    endtask

    task automatic run_traffic(input int count);
        int first;
        first = items_sent;
        while (items_sent - first < count)
            play_gesture();
    endtask

    initial
    begin
        win_now[sbgc_pkg::CFG_CYCLE_TIME] = sbgc_pkg::CYCLE_TIME_RESET;
        win_now[sbgc_pkg::CFG_SEGMENT_GAP] = sbgc_pkg::SEGMENT_GAP_RESET;
        win_now[sbgc_pkg::CFG_LIFT_CONFIRM] = sbgc_pkg::LIFT_CONFIRM_RESET;
        win_now[sbgc_pkg::CFG_CLICK_TIME] = sbgc_pkg::CLICK_TIME_RESET;
        win_now[sbgc_pkg::CFG_DOUBLE_CLICK_TIME] = sbgc_pkg::DOUBLE_CLICK_TIME_RESET;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, default windows. Unknown code with the largest value.
        post_event(16'hFFFF, 32'sh7FFF_FFFF, 48'd0);
        // plain click: press, release, release confirmed, report after window
        post_event(sbgc_pkg::CODE_STYLUS, 1, 48'd1000);
        post_event(sbgc_pkg::CODE_STYLUS, 0, 48'd2000);
        post_event(sbgc_pkg::CODE_SYN, 0, 48'd3000);
        post_event(sbgc_pkg::CODE_PRESSURE, 1, 48'd4000);
        post_event(sbgc_pkg::CODE_SYN, 0, 48'd500000);
        // hold on, hold off, then the long click it leaves due
        post_event(sbgc_pkg::CODE_STYLUS, 1, 48'd600000);
        post_event(sbgc_pkg::CODE_SYN, 0, 48'd850000);
        post_event(sbgc_pkg::CODE_STYLUS, 0, 48'd860000);
        post_event(sbgc_pkg::CODE_DISTANCE, 1, 48'd865000);
        post_event(sbgc_pkg::CODE_SYN, 0, 48'd870000);
        // contact, two segments, lift confirmed as pen up
        post_event(sbgc_pkg::CODE_DISTANCE, 0, 48'd900000);
        post_event(sbgc_pkg::CODE_PRESSURE, 0, 48'd901000);
        post_event(sbgc_pkg::CODE_PRESSURE, 0, 48'd902000);
        post_event(sbgc_pkg::CODE_DISTANCE, 1, 48'd903000);
        post_event(sbgc_pkg::CODE_SYN, 0, 48'd920000);
        // fake lift: button and contact seen during the lift window
        post_event(sbgc_pkg::CODE_DISTANCE, 0, 48'd930000);
        post_event(sbgc_pkg::CODE_DISTANCE, 1, 48'd931000);
        post_event(sbgc_pkg::CODE_STYLUS, 1, 48'd932000);
        post_event(sbgc_pkg::CODE_DISTANCE, 0, 48'd933000);
        // withdrawal and late return aborts everything
        post_event(sbgc_pkg::CODE_TOOL_PEN, 0, 48'd940000);
        post_event(sbgc_pkg::CODE_TOOL_PEN, 1, 48'd960000);
        // click report and hold off in one event: hold off carries count zero
        post_event(sbgc_pkg::CODE_STYLUS, 1, 48'd1000000);
        post_event(sbgc_pkg::CODE_STYLUS, 0, 48'd1001000);
        post_event(sbgc_pkg::CODE_PRESSURE, 1, 48'd1002000);
        post_event(sbgc_pkg::CODE_STYLUS, 0, 48'd1399000);
        post_event(sbgc_pkg::CODE_PRESSURE, 1, 48'd1401000);

        // Pile up presses at one instant, then let the hold-on and hold-off
        // report the accumulated count.
        post_event(sbgc_pkg::CODE_TOOL_PEN, 0, now_us + 1000);
        post_event(sbgc_pkg::CODE_TOOL_PEN, 1, now_us + 20000);
        repeat (BURST_PRESSES)
            post_event(sbgc_pkg::CODE_STYLUS, 1, now_us);
        post_event(sbgc_pkg::CODE_SYN, 0, now_us + 250000);
        post_event(sbgc_pkg::CODE_STYLUS, 0, now_us + 1000);
        post_event(sbgc_pkg::CODE_PRESSURE, 0, now_us + 1000);

        // top of the timestamp range with the most negative value
        post_event(sbgc_pkg::CODE_SYN, 32'sh8000_0000, 48'hFFFF_FFFF_FFFF);

        // Phase with no idling; the long receiver hold-off backs the block up.
        hold_off_requests = hold_off_requests + 1;
        run_traffic(ITEMS_PER_PHASE);

        // All windows zero, sender idles often.
        drain();
        program_windows('0, '0, '0, '0, '0);
        send_idle_pct = 62;
        recv_stall_pct = 0;
        run_traffic(ITEMS_PER_PHASE);

        // All windows at their largest, receiver stalls often.
        drain();
        program_windows('1, '1, '1, '1, '1);
        send_idle_pct = 0;
        recv_stall_pct = 62;
        run_traffic(ITEMS_PER_PHASE);

        // Short random windows, both sides idle now and then.
        drain();
        program_windows(sbgc_pkg::CFG_WIDTH'($urandom_range(0, 3000)),
                        sbgc_pkg::CFG_WIDTH'($urandom_range(0, 3000)),
                        sbgc_pkg::CFG_WIDTH'($urandom_range(0, 3000)),
                        sbgc_pkg::CFG_WIDTH'($urandom_range(0, 3000)),
                        sbgc_pkg::CFG_WIDTH'($urandom_range(0, 3000)));
        send_idle_pct = 28;
        recv_stall_pct = 28;
        run_traffic(ITEMS_PER_PHASE);

        // Windows anywhere in range, no idling.
        drain();
        program_windows(sbgc_pkg::CFG_WIDTH'($urandom_range(0, 24'hFFFFFF)),
                        sbgc_pkg::CFG_WIDTH'($urandom_range(0, 24'hFFFFFF)),
                        sbgc_pkg::CFG_WIDTH'($urandom_range(0, 24'hFFFFFF)),
                        sbgc_pkg::CFG_WIDTH'($urandom_range(0, 24'hFFFFFF)),
                        sbgc_pkg::CFG_WIDTH'($urandom_range(0, 24'hFFFFFF)));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_traffic(ITEMS_PER_PHASE);

        // Let every result come back, then watch a little longer for strays.
        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("** stylus_button_gesture_classifier: PASSED **");
        else
            $display("** stylus_button_gesture_classifier: FAILED **");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("timeout with %0d results still owed", results_owed);
        $display("** stylus_button_gesture_classifier: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
src/sbgc_pkg.sv
src/stylus_button_gesture_classifier.sv
verif/stylus_button_gesture_classifier_checker.sv
verif/stylus_button_gesture_classifier_tb.sv
